// ===== sv/hcrc_pkg.sv =====
// Shared types and constants for the HSV color range classifier.
// Used by every module of the block; depends on nothing else.
package hcrc_pkg;

  localparam int PixW            = 8;
  localparam int HueW            = 9;
  localparam int SatW            = 8;
  localparam int DenW            = 8;
  localparam int QuoW            = 8;
  localparam int NumW            = DenW + QuoW;
  localparam int HueNumW         = 14;
  localparam int DivBitsPerStage = 2;
  localparam int DivStages       = QuoW / DivBitsPerStage;
  localparam int PipeStages      = DivStages + 2;
  localparam int CfgIdxW         = 3;
  localparam int CfgDataW        = 9;
  localparam int InDataW         = 24;
  localparam int OutDataW        = 32;

  localparam logic [HueW-1:0] HueGreenBase = 9'd120;
  localparam logic [HueW-1:0] HueBlueBase  = 9'd240;
  localparam logic [HueW-1:0] HueFull      = 9'd360;
  localparam logic [HueW-1:0] HueMax       = 9'd359;

  typedef enum logic [1:0] {
    SecRed   = 2'd0,
    SecGreen = 2'd1,
    SecBlue  = 2'd2
  } sector_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHueLow  = 3'd0,
    CfgHueHigh = 3'd1,
    CfgSatLow  = 3'd2,
    CfgSatHigh = 3'd3,
    CfgValLow  = 3'd4,
    CfgValHigh = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [HueW-1:0] hue_low;
    logic [HueW-1:0] hue_high;
    logic [SatW-1:0] sat_low;
    logic [SatW-1:0] sat_high;
    logic [PixW-1:0] val_low;
    logic [PixW-1:0] val_high;
  } cfg_t;

  typedef struct packed {
    sector_e         sector;
    logic            neg;
    logic            delta_zero;
    logic [PixW-1:0] mx;
  } side_t;

  typedef struct packed {
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_in_t;

  typedef struct packed {
    logic [QuoW-1:0] quo;
    logic            rem_nz;
  } div_out_t;

endpackage

// ===== sv/hcrc_regs.sv =====
// Bound registers of the classifier, written over the configuration channel.
// Depends on hcrc_pkg.
module hcrc_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hcrc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [hcrc_pkg::CfgDataW-1:0] cfg_data_i,
  output hcrc_pkg::cfg_t               cfg_o
);
  import hcrc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgHueLow:  cfg_d.hue_low  = cfg_data_i[HueW-1:0];
        CfgHueHigh: cfg_d.hue_high = cfg_data_i[HueW-1:0];
        CfgSatLow:  cfg_d.sat_low  = cfg_data_i[SatW-1:0];
        CfgSatHigh: cfg_d.sat_high = cfg_data_i[SatW-1:0];
        CfgValLow:  cfg_d.val_low  = cfg_data_i[PixW-1:0];
        CfgValHigh: cfg_d.val_high = cfg_data_i[PixW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_low  <= '0;
      cfg_q.hue_high <= HueMax;
      cfg_q.sat_low  <= '0;
      cfg_q.sat_high <= '1;
      cfg_q.val_low  <= '0;
      cfg_q.val_high <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/hcrc_front.sv =====
// First pipeline stage: max, min, hue sector and the two dividends.
// Depends on hcrc_pkg.
module hcrc_front (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [hcrc_pkg::PixW-1:0] red_i,
  input  logic [hcrc_pkg::PixW-1:0] green_i,
  input  logic [hcrc_pkg::PixW-1:0] blue_i,
  output hcrc_pkg::div_in_t         hue_div_o,
  output hcrc_pkg::div_in_t         sat_div_o,
  output hcrc_pkg::side_t           side_o
);
  import hcrc_pkg::*;

  logic [PixW-1:0]    mx, mn, delta, diff;
  logic [HueNumW-1:0] hue_num;
  logic [NumW-1:0]    sat_num;
  side_t              side_d, side_q;
  div_in_t            hue_d, hue_q, sat_d, sat_q;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx)  mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn)  mn = blue_i;
    delta = mx - mn;

    side_d.mx         = mx;
    side_d.delta_zero = (delta == '0);
    if (mx == red_i) begin
      side_d.sector = SecRed;
      side_d.neg    = (blue_i > green_i);
      diff          = side_d.neg ? blue_i - green_i : green_i - blue_i;
    end else if (mx == green_i) begin
      side_d.sector = SecGreen;
      side_d.neg    = (red_i > blue_i);
      diff          = side_d.neg ? red_i - blue_i : blue_i - red_i;
    end else begin
      side_d.sector = SecBlue;
      side_d.neg    = (green_i > red_i);
      diff          = side_d.neg ? green_i - red_i : red_i - green_i;
    end

    hue_num   = {diff, 6'b0} - {4'b0, diff, 2'b0};
    sat_num   = {delta, 8'b0} - {8'b0, delta};
    hue_d.num = {{(NumW-HueNumW){1'b0}}, hue_num};
    hue_d.den = delta;
    sat_d.num = sat_num;
    sat_d.den = mx;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      hue_q  <= hue_d;
      sat_q  <= sat_d;
    end
  end

  assign hue_div_o = hue_q;
  assign sat_div_o = sat_q;
  assign side_o    = side_q;

endmodule

// ===== sv/hcrc_div.sv =====
// Pipelined restoring divider for a quotient known to fit in QuoW bits.
// Retires DivBitsPerStage quotient bits per register stage; depends on hcrc_pkg.
module hcrc_div (
  input  logic                           clk_i,
  input  logic [hcrc_pkg::DivStages-1:0] en_i,
  input  hcrc_pkg::div_in_t              div_i,
  output hcrc_pkg::div_out_t             div_o
);
  import hcrc_pkg::*;

  typedef struct packed {
    logic [DenW:0]   rem;
    logic [QuoW-1:0] low;
    logic [QuoW-1:0] quo;
    logic [DenW-1:0] den;
  } lane_t;

  function automatic lane_t div_step(lane_t l);
    lane_t         r;
    logic [DenW:0] t;
    r = l;
    for (int i = 0; i < DivBitsPerStage; i++) begin
      t     = {r.rem[DenW-1:0], r.low[QuoW-1]};
      r.low = {r.low[QuoW-2:0], 1'b0};
      if (t >= {1'b0, r.den}) begin
        r.rem = t - {1'b0, r.den};
        r.quo = {r.quo[QuoW-2:0], 1'b1};
      end else begin
        r.rem = t;
        r.quo = {r.quo[QuoW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  lane_t init;
  lane_t lane_d [DivStages];
  lane_t lane_q [DivStages];

  always_comb begin
    init.rem  = {1'b0, div_i.num[NumW-1:QuoW]};
    init.low  = div_i.num[QuoW-1:0];
    init.quo  = '0;
    init.den  = div_i.den;
    lane_d[0] = div_step(init);
    for (int k = 1; k < DivStages; k++) begin
      lane_d[k] = div_step(lane_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DivStages; k++) begin
      if (en_i[k]) begin
        lane_q[k] <= lane_d[k];
      end
    end
  end

  assign div_o.quo    = lane_q[DivStages-1].quo;
  assign div_o.rem_nz = |lane_q[DivStages-1].rem;

endmodule

// ===== sv/hcrc_back.sv =====
// Last pipeline stage: hue from the sector quotient, saturation, bound compare.
// Holds the output register; depends on hcrc_pkg.
module hcrc_back (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  hcrc_pkg::div_out_t        hue_div_i,
  input  hcrc_pkg::div_out_t        sat_div_i,
  input  hcrc_pkg::side_t           side_i,
  input  hcrc_pkg::cfg_t            cfg_i,
  output logic                      in_range_o,
  output logic [hcrc_pkg::HueW-1:0] hue_o,
  output logic [hcrc_pkg::SatW-1:0] sat_o,
  output logic [hcrc_pkg::PixW-1:0] val_o
);
  import hcrc_pkg::*;

  logic [HueW-1:0] qx, rnz, hue_d, hue_q;
  logic [SatW-1:0] sat_d, sat_q;
  logic [PixW-1:0] val_q;
  logic            ok_d, ok_q;

  always_comb begin
    qx  = {1'b0, hue_div_i.quo};
    rnz = {{(HueW-1){1'b0}}, hue_div_i.rem_nz};
    case (side_i.sector)
      SecRed:   hue_d = side_i.neg ? ((qx == '0) ? '0 : HueFull - qx) : qx;
      SecGreen: hue_d = side_i.neg ? HueGreenBase - qx - rnz : HueGreenBase + qx;
      SecBlue:  hue_d = side_i.neg ? HueBlueBase - qx - rnz : HueBlueBase + qx;
      default:  hue_d = '0;
    endcase
    if (side_i.delta_zero) hue_d = '0;
    sat_d = (side_i.mx == '0) ? '0 : sat_div_i.quo;
    ok_d  = (hue_d >= cfg_i.hue_low) && (hue_d <= cfg_i.hue_high) &&
            (sat_d >= cfg_i.sat_low) && (sat_d <= cfg_i.sat_high) &&
            (side_i.mx >= cfg_i.val_low) && (side_i.mx <= cfg_i.val_high);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= side_i.mx;
      ok_q  <= ok_d;
    end
  end

  assign in_range_o = ok_q;
  assign hue_o      = hue_q;
  assign sat_o      = sat_q;
  assign val_o      = val_q;

endmodule

// ===== sv/hsv_color_range_classifier.sv =====
// Top level of the HSV color range classifier: pipeline control and stages.
// Depends on hcrc_pkg, hcrc_regs, hcrc_front, hcrc_div and hcrc_back.
//
//   channel   direction  payload (lowest bits first)
//   s_axis    in         red, green, blue
//   m_axis    out        in_range, hue, saturation, brightness
//   cfg       in         register index, bound value
//
// One pixel enters per clock while the output is not stalled; its result passes through
// the front stage, four divider stages and the output register.
// Reset clears all stage valid bits and loads the default bounds.
// A stalled output holds its stage; earlier stages keep filling empty slots.
module hsv_color_range_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [hcrc_pkg::InDataW-1:0]  s_axis_tdata,  // red, green, blue
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [hcrc_pkg::OutDataW-1:0] m_axis_tdata,  // in_range, hue, sat, brightness, zeros
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hcrc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hcrc_pkg::CfgDataW-1:0] cfg_data_i
);
  import hcrc_pkg::*;

  cfg_t                  cfg;
  div_in_t               hue_div_in, sat_div_in;
  div_out_t              hue_div_out, sat_div_out;
  side_t                 side_front;
  side_t                 side_q [DivStages];
  logic [PipeStages-1:0] en, vld_q, vld_d;
  logic                  in_range;
  logic [HueW-1:0]       hue;
  logic [SatW-1:0]       sat;
  logic [PixW-1:0]       val;

  hcrc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  always_comb begin
    en[PipeStages-1] = !vld_q[PipeStages-1] || m_axis_tready;
    for (int k = PipeStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < PipeStages; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = en[0];

  hcrc_front u_front (
    .clk_i     (clk_i),
    .en_i      (en[0]),
    .red_i     (s_axis_tdata[7:0]),
    .green_i   (s_axis_tdata[15:8]),
    .blue_i    (s_axis_tdata[23:16]),
    .hue_div_o (hue_div_in),
    .sat_div_o (sat_div_in),
    .side_o    (side_front)
  );

  hcrc_div u_hue_div (
    .clk_i (clk_i),
    .en_i  (en[DivStages:1]),
    .div_i (hue_div_in),
    .div_o (hue_div_out)
  );

  hcrc_div u_sat_div (
    .clk_i (clk_i),
    .en_i  (en[DivStages:1]),
    .div_i (sat_div_in),
    .div_o (sat_div_out)
  );

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DivStages; k++) begin
      if (en[k+1]) begin
        side_q[k] <= (k == 0) ? side_front : side_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  hcrc_back u_back (
    .clk_i      (clk_i),
    .en_i       (en[PipeStages-1]),
    .hue_div_i  (hue_div_out),
    .sat_div_i  (sat_div_out),
    .side_i     (side_q[DivStages-1]),
    .cfg_i      (cfg),
    .in_range_o (in_range),
    .hue_o      (hue),
    .sat_o      (sat),
    .val_o      (val)
  );

  assign m_axis_tvalid = vld_q[PipeStages-1];
  assign m_axis_tdata  = {{(OutDataW-1-HueW-SatW-PixW){1'b0}}, val, sat, hue, in_range};

  // The input side only stalls once every stage holds a pixel.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&vld_q))
    else $error("input stalled while the pipeline has an empty stage");

  // An accepted pixel always lands in the front stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted pixel lost at the front stage");

  a_hue_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (hue <= HueMax))
    else $error("hue out of range");

  a_black_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (val == '0)) |-> ((sat == '0) && (hue == '0)))
    else $error("black pixel with nonzero hue or saturation");

endmodule

// ===== bench/tb_hsv_color_range_classifier.sv =====
`timescale 1ns / 1ps
// Testbench for hsv_color_range_classifier: drives pixels and bound writes,
// predicts hue, saturation, brightness and the in-range flag, checks each output.
// Depends on hcrc_pkg and the hsv_color_range_classifier RTL.
module tb_hsv_color_range_classifier;
  import hcrc_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 3'd7;

  typedef struct packed {
    logic            in_range;
    logic [HueW-1:0] hue;
    logic [SatW-1:0] saturation;
    logic [PixW-1:0] brightness;
  } hsv_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i = '0;
  logic [CfgDataW-1:0]   cfg_data_i = '0;

  logic [HueW-1:0] hue_lo = 9'd0;
  logic [HueW-1:0] hue_hi = 9'd359;
  logic [SatW-1:0] sat_lo = 8'd0;
  logic [SatW-1:0] sat_hi = 8'd255;
  logic [PixW-1:0] val_lo = 8'd0;
  logic [PixW-1:0] val_hi = 8'd255;

  hsv_result_t expected_hsv_q[$];
  int          mismatch_count = 0;
  int          stall_cycles = 0;
  bit          idle_off = 1'b0;

  hsv_color_range_classifier u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic hsv_result_t predict_hsv(input logic [PixW-1:0] r, g, b);
    int unsigned ri, gi, bi, mx, mn, delta, q, h, s;
    hsv_result_t res;
    ri = 32'(r);
    gi = 32'(g);
    bi = 32'(b);
    mx = ri;
    mn = ri;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    delta = mx - mn;
    h = 0;
    if (delta != 0) begin
      if (mx == ri) begin
        if (gi >= bi) begin
          h = (60 * (gi - bi)) / delta;
        end else begin
          q = (60 * (bi - gi)) / delta;
          h = (q == 0) ? 0 : 360 - q;
        end
      end else if (mx == gi) begin
        h = (120 * delta + 60 * bi - 60 * ri) / delta;
      end else begin
        h = (240 * delta + 60 * ri - 60 * gi) / delta;
      end
    end
    s = (mx != 0) ? (255 * delta) / mx : 0;
    res.hue        = h[HueW-1:0];
    res.saturation = s[SatW-1:0];
    res.brightness = mx[PixW-1:0];
    res.in_range   = (h >= hue_lo) && (h <= hue_hi) && (s >= sat_lo) && (s <= sat_hi) &&
                     (mx >= val_lo) && (mx <= val_hi);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_hsv(input logic [OutDataW-1:0] d);
    hsv_result_t want;
    hsv_result_t got;
    got.in_range   = d[0];
    got.hue        = d[9:1];
    got.saturation = d[17:10];
    got.brightness = d[25:18];
    if (expected_hsv_q.size() == 0) begin
      report_mismatch($sformatf("unexpected output transfer %h", d));
    end else begin
      want = expected_hsv_q.pop_front();
      if (got.in_range !== want.in_range)
        report_mismatch($sformatf("in_range %b, want %b", got.in_range, want.in_range));
      if (got.hue !== want.hue)
        report_mismatch($sformatf("hue %0d, want %0d", got.hue, want.hue));
      if (got.saturation !== want.saturation)
        report_mismatch($sformatf("saturation %0d, want %0d", got.saturation,
                                  want.saturation));
      if (got.brightness !== want.brightness)
        report_mismatch($sformatf("brightness %0d, want %0d", got.brightness,
                                  want.brightness));
    end
  endtask

  // The receiver samples at each rising edge, then picks its ready for the next cycle.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_hsv(m_axis_tdata);
      if (stall_cycles > 0) begin
        stall_cycles--;
        m_axis_tready <= 1'b0;
      end else if (!idle_off && $urandom_range(99) < 24) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_pixel(input logic [PixW-1:0] r, g, b);
    if (!idle_off && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_hsv_q.push_back(predict_hsv(r, g, b));
  endtask

  task automatic send_random_pixel();
    logic [PixW-1:0] r, g, b, base;
    r = 8'($urandom_range(255));
    g = 8'($urandom_range(255));
    b = 8'($urandom_range(255));
    base = 8'($urandom_range(255));
    case ($urandom_range(9))
      0: begin
        g = r;
        b = r;
      end
      1: begin
        case ($urandom_range(2))
          0: g = r;
          1: b = g;
          default: b = r;
        endcase
      end
      2: begin
        r = $urandom_range(1) ? 8'd255 : 8'd0;
        g = $urandom_range(1) ? 8'd255 : 8'd0;
        b = $urandom_range(1) ? 8'd255 : 8'd0;
      end
      3: begin
        r = base ^ 8'($urandom_range(3));
        g = base ^ 8'($urandom_range(3));
        b = base ^ 8'($urandom_range(3));
      end
      default: ;
    endcase
    send_pixel(r, g, b);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_hsv_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high so that writes can go back to back.
  task automatic write_bound(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgHueLow:  hue_lo = val;
      CfgHueHigh: hue_hi = val;
      CfgSatLow:  sat_lo = val[SatW-1:0];
      CfgSatHigh: sat_hi = val[SatW-1:0];
      CfgValLow:  val_lo = val[PixW-1:0];
      CfgValHigh: val_hi = val[PixW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_bounds(input logic [CfgDataW-1:0] hl, hh, sl, sh, vl, vh);
    drain();
    write_bound(CfgHueLow, hl);
    write_bound(CfgHueHigh, hh);
    write_bound(CfgSatLow, sl);
    write_bound(CfgSatHigh, sh);
    write_bound(CfgValLow, vl);
    write_bound(CfgValHigh, vh);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_random_bounds();
    int unsigned hl, hh, sl, sh, vl, vh;
    hl = $urandom_range(0, 359);
    hh = $urandom_range(hl, 359);
    sl = $urandom_range(0, 160);
    sh = $urandom_range(sl, 255);
    vl = $urandom_range(0, 160);
    vh = $urandom_range(vl, 255);
    if ($urandom_range(3) == 0) begin
      hl = $urandom_range(0, 511);
      hh = $urandom_range(0, 511);
      sl = $urandom_range(0, 511);
      vh = $urandom_range(0, 511);
    end
    set_bounds(CfgDataW'(hl), CfgDataW'(hh), CfgDataW'(sl), CfgDataW'(sh),
               CfgDataW'(vl), CfgDataW'(vh));
  endtask

  task automatic test_color_cases();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd10);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd10, 8'd200, 8'd30);
    send_pixel(8'd30, 8'd10, 8'd200);
    send_pixel(8'd200, 8'd30, 8'd10);
    send_pixel(8'd254, 8'd255, 8'd253);
  endtask

  task automatic test_bound_extremes();
    set_bounds(9'd0, 9'd359, 9'd0, 9'd255, 9'd0, 9'd255);
    repeat (30) send_random_pixel();
    set_bounds(9'd359, 9'd0, 9'd255, 9'd0, 9'd255, 9'd0);
    repeat (30) send_random_pixel();
    set_bounds(9'd300, 9'd511, 9'd1, 9'd254, 9'd1, 9'd254);
    repeat (30) send_random_pixel();
    set_bounds(9'd511, 9'd511, 9'd0, 9'd255, 9'd0, 9'd255);
    repeat (30) send_random_pixel();
    set_bounds(9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd255);
    repeat (30) send_random_pixel();
  endtask

  task automatic test_spare_index();
    set_bounds(9'd60, 9'd240, 9'd40, 9'd220, 9'd30, 9'd230);
    write_bound(CfgSpareA, 9'd0);
    write_bound(CfgSpareB, 9'd511);
    cfg_valid_i <= 1'b0;
    repeat (30) send_random_pixel();
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < 10; phase++) begin
      set_random_bounds();
      idle_off = (phase == 4);
      repeat (100) send_random_pixel();
    end
    idle_off = 1'b0;
  endtask

  task automatic test_output_stall();
    set_random_bounds();
    stall_cycles = 300;
    repeat (60) send_random_pixel();
    drain();
    repeat (40) send_random_pixel();
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_color_cases();
    test_bound_extremes();
    test_spare_index();
    test_random_stream();
    test_output_stall();
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
